// ===== src/irt_pkg.sv =====
// Shared constants, types and codes for the interval reservation table.
`timescale 1ns / 1ps
`default_nettype none
package irt_pkg;

    localparam int CAPACITY  = 64;
    localparam int TIME_BITS = 32;
    localparam int IDX_BITS  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_BITS  = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        ST_ACCEPTED = 2'd0,
        ST_OVERLAP  = 2'd1,
        ST_FULL     = 2'd2,
        ST_INVALID  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;    // capture request, restart scan
        logic rd_en;   // read next stored entry
        logic finish;  // decide, commit, post result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic invalid;    // start not below end
        logic scan_more;  // entries left to read
        logic scan_done;  // all reads issued and compared
        logic out_busy;   // result register occupied and stalled
    } t_dp_status;

endpackage
`default_nettype wire

// ===== src/irt_ctrl.sv =====
// Request sequencer: accept, scan the table, post one result.
`timescale 1ns / 1ps
`default_nettype none
module irt_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire irt_pkg::t_dp_status i_dp,
    output irt_pkg::t_cmd            o_cmd
);
    import irt_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_stall      = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_dp.invalid) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.rd_en = i_dp.scan_more;
                    if (i_dp.scan_done) begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_FINISH: begin
                if (!i_dp.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== src/irt_dp.sv =====
// Table storage, overlap compare, entry count and result register.
`timescale 1ns / 1ps
`default_nettype none
module irt_dp (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [31:0]       i_start_time,
    input  wire logic [31:0]       i_end_time,
    input  wire irt_pkg::t_cmd     i_cmd,
    output irt_pkg::t_dp_status    o_dp,
    input  wire logic              i_stall,
    output logic                   o_valid,
    output logic [1:0]             o_status,
    output logic [6:0]             o_entries_used
);
    import irt_pkg::*;

    logic [2*TIME_BITS-1:0] mem [CAPACITY];

    logic [TIME_BITS-1:0]   r_lo;
    logic [TIME_BITS-1:0]   r_hi;
    logic [CNT_BITS-1:0]    r_count;
    logic [CNT_BITS-1:0]    r_idx;
    logic [2*TIME_BITS-1:0] r_rd_data;
    logic                   r_rd_vld;
    logic                   r_hit;
    logic                   r_out_valid;
    t_status                r_status;
    logic [6:0]             r_used;

    logic [63:0]            start_w;
    logic [63:0]            end_w;
    logic [63:0]            count_w;
    logic [TIME_BITS-1:0]   rd_start;
    logic [TIME_BITS-1:0]   rd_end;
    logic                   cmp_hit;
    logic                   table_full;
    t_status                n_status;
    logic [CNT_BITS-1:0]    n_count;

    // fold the port width onto the time width
    assign start_w  = {32'b0, i_start_time};
    assign end_w    = {32'b0, i_end_time};
    assign rd_start = r_rd_data[2*TIME_BITS-1:TIME_BITS];
    assign rd_end   = r_rd_data[TIME_BITS-1:0];
    assign cmp_hit  = r_rd_vld && (rd_start < r_hi) && (r_lo < rd_end);

    assign table_full = (r_count == CNT_BITS'(CAPACITY));

    always_comb begin
        n_count = r_count;
        if (r_lo >= r_hi) begin
            n_status = ST_INVALID;
        end else if (r_hit) begin
            n_status = ST_OVERLAP;
        end else if (table_full) begin
            n_status = ST_FULL;
        end else begin
            n_status = ST_ACCEPTED;
            n_count  = r_count + 1'b1;
        end
    end

    assign o_dp.invalid   = (r_lo >= r_hi);
    assign o_dp.scan_more = (r_idx < r_count);
    assign o_dp.scan_done = !(r_idx < r_count) && !r_rd_vld;
    assign o_dp.out_busy  = r_out_valid && i_stall;

    // table storage
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish && n_status == ST_ACCEPTED) begin
            mem[r_count[IDX_BITS-1:0]] <= {r_lo, r_hi};
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[r_idx[IDX_BITS-1:0]];
        end
    end

    // request payload and result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_lo <= start_w[TIME_BITS-1:0];
            r_hi <= end_w[TIME_BITS-1:0];
        end
        if (i_cmd.finish) begin
            r_status <= n_status;
            r_used   <= count_w[6:0];
        end
    end

    assign count_w = 64'(n_count);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_idx       <= '0;
            r_rd_vld    <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_en;
            if (i_cmd.load) begin
                r_idx <= '0;
                r_hit <= 1'b0;
            end else begin
                if (i_cmd.rd_en) begin
                    r_idx <= r_idx + 1'b1;
                end
                if (cmp_hit) begin
                    r_hit <= 1'b1;
                end
            end
            if (i_cmd.finish) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_status;
    assign o_entries_used = r_used;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(CAPACITY))
        else $error("entry count above capacity");

    a_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> !r_rd_vld)
        else $error("decision taken with a table read in flight");

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_en |-> (r_idx < r_count))
        else $error("scan read beyond stored entries");

    a_commit_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && n_status == ST_ACCEPTED) |=> (r_count == $past(r_count) + 1'b1))
        else $error("accepted booking did not add an entry");

endmodule
`default_nettype wire

// ===== src/interval_reservation_table_top.sv =====
// Top level of the interval reservation table: sequencer plus datapath.
// Flow: the request beat is captured, the scan reads each stored interval through a
//   registered read and compares it, the last read drains, then the decision is taken
//   and the result beat is offered; an invalid request or an empty table skips the scan.
// Throughput: a new request is taken only after the previous result is posted, and the
//   scan is set by the single read port of the table, walked one entry per cycle.
// Reset: synchronous active low; the table is empty and no clearing pass runs.
`timescale 1ns / 1ps
`default_nettype none
module interval_reservation_table_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request channel
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [31:0] i_start_time,
    input  wire logic [31:0] i_end_time,
    // result channel
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_status,
    output logic [6:0]       o_entries_used
);
    import irt_pkg::*;

    t_cmd       cmd;
    t_dp_status dp_status;

    // Sequencer: takes a request beat only when idle, walks the stored entries
    // of a valid request, then holds the decision until the result register is free.
    irt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_dp    (dp_status),
        .o_cmd   (cmd)
    );

    // Datapath: the table itself, the overlap compare on each registered
    // read, the entry count and the result register that parts the result
    // channel from the next request.
    irt_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start_time   (i_start_time),
        .i_end_time     (i_end_time),
        .i_cmd          (cmd),
        .o_dp           (dp_status),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_entries_used (o_entries_used)
    );

endmodule
`default_nettype wire
